[src/blr_pkg.sv]
// ----------------------------------------------------------------------------
// blr_pkg - shared types and constants for the line rasteriser
// Payload structs, register indexes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package blr_pkg;

	localparam int COORD_BITS  = 6;   // coordinate width of a line command
	localparam int SCREEN_BITS = 7;   // width of the screen size registers
	localparam int INDEX_BITS  = 13;  // width of a frame-buffer index
	localparam int COLOUR_BITS = 3;
	localparam int CODE_BITS   = 6;

	localparam logic [SCREEN_BITS-1:0] SCREEN_MAX     = 7'd64;
	localparam logic [SCREEN_BITS-1:0] SCREEN_DEFAULT = 7'd10;
	localparam logic [CODE_BITS-1:0]   COLOUR_BASE    = 6'd30;

	typedef enum logic [0:0] {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_END,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic [COORD_BITS-1:0]  start_x;
		logic [COORD_BITS-1:0]  start_y;
		logic [COORD_BITS-1:0]  end_x;
		logic [COORD_BITS-1:0]  end_y;
		logic [COLOUR_BITS-1:0] colour;
	} line_cmd_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] pixel_index;
		logic [CODE_BITS-1:0]  colour_code;
		logic                  last_pixel;
	} pixel_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // latch a new line request and set up the walk
		logic emit_end;   // emit the end point
		logic emit_walk;  // emit the current walk point and step
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;    // output register can take a pixel this cycle
		logic degenerate;  // start equals end: the end point is the only pixel
		logic walk_last;   // the next step lands on the end point
	} dp_sts_t;

endpackage

[src/blr_ctrl.sv]
// ----------------------------------------------------------------------------
// blr_ctrl - line walk controller
// Sequences setup, end point emission and the walk, one line at a time.
// ----------------------------------------------------------------------------
module blr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  blr_pkg::dp_sts_t sts,
	output blr_pkg::dp_cmd_t cmd
);

	blr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			blr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = blr_pkg::ST_END;
				end
			end
			blr_pkg::ST_END: begin
				if (sts.out_free) begin
					cmd.emit_end = 1'b1;
					state_d      = sts.degenerate ? blr_pkg::ST_IDLE : blr_pkg::ST_WALK;
				end
			end
			blr_pkg::ST_WALK: begin
				if (sts.out_free) begin
					cmd.emit_walk = 1'b1;
					if (sts.walk_last) begin
						state_d = blr_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = blr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[src/blr_datapath.sv]
// ----------------------------------------------------------------------------
// blr_datapath - Bresenham walk registers, index mapping and output register
// Holds the screen size registers, the walk point and error term, and the
// registered pixel result.
// ----------------------------------------------------------------------------
module blr_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  blr_pkg::reg_idx_t                   cfg_index,
	input  logic [blr_pkg::SCREEN_BITS-1:0]     cfg_data,
	input  blr_pkg::line_cmd_t                  in_data,
	input  blr_pkg::dp_cmd_t                    cmd,
	output blr_pkg::dp_sts_t                    sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output blr_pkg::pixel_t                     out_data
);

	localparam int N     = blr_pkg::COORD_BITS;
	localparam int SB    = blr_pkg::SCREEN_BITS;
	localparam int IW    = blr_pkg::INDEX_BITS;
	localparam int CB    = blr_pkg::CODE_BITS;
	localparam int ERR_W = N + 2;
	localparam int E2_W  = N + 3;
	localparam int CMP_W = (N > SB) ? N : SB;

	// on-screen test and row-major mapping, 1-based coordinates
	function automatic logic [IW-1:0] pixel_slot(
		input logic [N-1:0]  x,
		input logic [N-1:0]  y,
		input logic [SB-1:0] w,
		input logic [SB-1:0] h
	);
		logic          on_screen;
		logic [N-1:0]  ym1;
		logic [SB-2:0] row;
		on_screen = (x != '0) && (y != '0) &&
		            (CMP_W'(x) <= CMP_W'(w)) && (CMP_W'(y) <= CMP_W'(h));
		ym1       = y - N'(1);
		row       = (SB-1)'(ym1);
		return on_screen ? (IW'(row) * IW'(w) + IW'(x)) : '0;
	endfunction

	logic [SB-1:0] width_q, height_q;
	logic [SB-1:0] cfg_clamped;

	logic [N-1:0]  cur_x_q, cur_y_q, tgt_x_q, tgt_y_q, dx_q, dy_q;
	logic          sx_neg_q, sy_neg_q;
	logic signed [ERR_W-1:0] err_q;
	logic [blr_pkg::COLOUR_BITS-1:0] colour_q;

	blr_pkg::pixel_t out_q;
	logic            out_valid_q;

	// setup from the incoming request
	logic [N-1:0] dx_in, dy_in;
	logic signed [ERR_W-1:0] err_in;

	// walk step
	logic signed [E2_W-1:0] e2, dx_e, dy_e, err_e, err_sum;
	logic                   go_x, go_y;
	logic [N-1:0]           nx, ny;

	logic [N-1:0] px, py;
	logic         emit;

	assign cfg_clamped = (cfg_data > blr_pkg::SCREEN_MAX) ? blr_pkg::SCREEN_MAX : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= blr_pkg::SCREEN_DEFAULT;
			height_q <= blr_pkg::SCREEN_DEFAULT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				blr_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_clamped;
				blr_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_clamped;
				default: ;
			endcase
		end
	end

	assign dx_in  = (in_data.end_x > in_data.start_x) ? in_data.end_x - in_data.start_x
	                                                 : in_data.start_x - in_data.end_x;
	assign dy_in  = (in_data.end_y > in_data.start_y) ? in_data.end_y - in_data.start_y
	                                                 : in_data.start_y - in_data.end_y;
	assign err_in = $signed({2'b00, dx_in}) - $signed({2'b00, dy_in});

	assign e2      = $signed({err_q, 1'b0});
	assign dx_e    = $signed({3'b000, dx_q});
	assign dy_e    = $signed({3'b000, dy_q});
	assign err_e   = $signed({err_q[ERR_W-1], err_q});
	assign go_x    = e2 > -dy_e;
	assign go_y    = e2 < dx_e;
	assign err_sum = err_e - (go_x ? dy_e : '0) + (go_y ? dx_e : '0);

	assign nx = go_x ? (sx_neg_q ? cur_x_q - N'(1) : cur_x_q + N'(1)) : cur_x_q;
	assign ny = go_y ? (sy_neg_q ? cur_y_q - N'(1) : cur_y_q + N'(1)) : cur_y_q;

	// walk state: payload only, set up by every request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_x_q  <= in_data.start_x;
			cur_y_q  <= in_data.start_y;
			tgt_x_q  <= in_data.end_x;
			tgt_y_q  <= in_data.end_y;
			dx_q     <= dx_in;
			dy_q     <= dy_in;
			sx_neg_q <= !(in_data.start_x < in_data.end_x);
			sy_neg_q <= !(in_data.start_y < in_data.end_y);
			err_q    <= err_in;
			colour_q <= in_data.colour;
		end else if (cmd.emit_walk) begin
			cur_x_q <= nx;
			cur_y_q <= ny;
			err_q   <= err_sum[ERR_W-1:0];
		end
	end

	assign emit = cmd.emit_end | cmd.emit_walk;
	assign px   = cmd.emit_end ? tgt_x_q : cur_x_q;
	assign py   = cmd.emit_end ? tgt_y_q : cur_y_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.pixel_index <= pixel_slot(px, py, width_q, height_q);
			out_q.colour_code <= CB'(colour_q) + blr_pkg::COLOUR_BASE;
			out_q.last_pixel  <= cmd.emit_end ? sts.degenerate : sts.walk_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.degenerate = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
	assign sts.walk_last  = (nx == tgt_x_q) && (ny == tgt_y_q);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[src/bresenham_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer - integer Bresenham line walker
// Turns one line request into a stream of frame-buffer indexes and colour
// codes: end point first, then start point onwards, stopping short of the end.
// ----------------------------------------------------------------------------
//
//  channel | signals                                  | carries
//  --------+------------------------------------------+---------------------------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data   | screen width / height
//  in      | in_valid in_ready in_data                | line request (2 pts, colour)
//  out     | out_valid out_ready out_data             | pixel index, code, last
//
// A request is first loaded into the walk registers, then emits one pixel
// per cycle while the output is not stalled, 1 + max(|dx|,|dy|) pixels in all.
// The walk loop in the datapath sets that pixel count.
// A stalled output holds the walk; the single output register lets the next
// request be taken while the final pixel of a line still waits.
// Reset restores 10 x 10 and leaves the block idle; config is always ready.
//
module bresenham_line_rasterizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  blr_pkg::reg_idx_t               cfg_index,
	input  logic [blr_pkg::SCREEN_BITS-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  blr_pkg::line_cmd_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output blr_pkg::pixel_t                 out_data
);

	blr_pkg::dp_cmd_t cmd;
	blr_pkg::dp_sts_t sts;

	// size registers take a write in any cycle
	assign cfg_ready = 1'b1;

	blr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	blr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a taken request keeps the input closed for at least the setup cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready straight after a request was taken");

	// a pixel is only written into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_end || cmd.emit_walk) |-> sts.out_free)
		else $error("pixel emitted over a result still waiting");

	// the pixel marked last closes the line and reopens the input
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_walk && sts.walk_last) || (cmd.emit_end && sts.degenerate)
		|=> in_ready && out_valid && out_data.last_pixel)
		else $error("last pixel did not return the block to idle");

	// colour codes stay within the foreground range
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.colour_code >= 6'd30) && (out_data.colour_code <= 6'd37))
		else $error("colour code out of range");

endmodule
